>>> rtl/hfr_pkg.sv
// ----------------------------------------------------------------------------
// HTTP/3 frame framer package
// Shared types, constants and header byte helpers.
// ----------------------------------------------------------------------------
package hfr_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [31:0] VARINT1_MAX = 32'd63;
    localparam logic [31:0] VARINT2_MAX = 32'd16383;
    localparam logic [31:0] VARINT4_MAX = 32'd1073741823;
    localparam logic [7:0]  PREFIX2     = 8'h40;
    localparam logic [7:0]  PREFIX4     = 8'h80;
    localparam logic [7:0]  PREFIX8     = 8'hC0;

    typedef enum logic {
        OP_START,
        OP_PAYLOAD
    } op_e_t;

    typedef enum logic [1:0] {
        ERR_OK,
        ERR_DROP,
        ERR_CUT
    } err_t;

    typedef enum logic [1:0] {
        VLEN_1,
        VLEN_2,
        VLEN_4,
        VLEN_8
    } vlen_t;

    typedef struct packed {
        logic        is_hdr;
        vlen_t       vlen;
        logic [5:0]  ftype;
        logic [31:0] len;
        logic [7:0]  data;
        logic        frame_end;
        err_t        err;
    } cmd_t;

    function automatic logic [3:0] hdr_last(input vlen_t vlen);
        logic [3:0] r;
        unique case (vlen)
            VLEN_1:  r = 4'd1;
            VLEN_2:  r = 4'd2;
            VLEN_4:  r = 4'd4;
            VLEN_8:  r = 4'd8;
            default: r = 4'd1;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hdr_byte(input logic [5:0] ftype, input logic [31:0] len,
                                            input vlen_t vlen, input logic [3:0] idx);
        logic [7:0] r;
        r = 8'h00;
        if (idx == 4'd0)
        begin
            r = {2'b00, ftype};
        end
        else
        begin
            unique case (vlen)
                VLEN_1:
                begin
                    r = len[7:0];
                end
                VLEN_2:
                begin
                    r = (idx == 4'd1) ? (PREFIX2 | {2'b00, len[13:8]}) : len[7:0];
                end
                VLEN_4:
                begin
                    unique case (idx)
                        4'd1:    r = PREFIX4 | {2'b00, len[29:24]};
                        4'd2:    r = len[23:16];
                        4'd3:    r = len[15:8];
                        default: r = len[7:0];
                    endcase
                end
                VLEN_8:
                begin
                    unique case (idx)
                        4'd1:    r = PREFIX8;
                        4'd5:    r = len[31:24];
                        4'd6:    r = len[23:16];
                        4'd7:    r = len[15:8];
                        4'd8:    r = len[7:0];
                        default: r = 8'h00;
                    endcase
                end
                default:
                begin
                    r = 8'h00;
                end
            endcase
        end
        return r;
    endfunction

endpackage

>>> rtl/http3_frame_header_framer_top.sv
// ----------------------------------------------------------------------------
// HTTP/3 frame header framer
// Turns start and payload transfers into an HTTP/3 frame byte stream.
//
// Input channel s_*: tuser selects start (0) or payload byte (1). A start
// yields the type byte and the QUIC varint length (1, 2, 4 or 8 bytes), a
// payload transfer yields one byte. Output channel m_*: one byte per
// transfer, tlast on the final byte of a frame, tuser carries the run end
// flag and the error code.
// A taken transfer goes into the command queue, then its first byte into the
// registered output stage. Throughput: one output byte per cycle while the
// receiver is ready and a command waits; the byte emitter walks a start out
// as 2, 3, 5 or 9 bytes, while the four-entry queue keeps taking input transfers.
// Reset clears the open frame, the queue and the output stage.
// When the receiver stalls, the output byte holds, the queue fills and
// s_tready drops once four commands are waiting.
// ----------------------------------------------------------------------------
module http3_frame_header_framer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // type_code[5:0], payload_length[37:6], payload_byte[45:38]
    input  logic [0:0]  s_tuser,   // opcode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast,
    output logic [2:0]  m_tuser    // run_end[0], error[2:1]
);
    import hfr_pkg::*;

    logic accept;
    logic full;
    logic empty;
    logic pop;
    cmd_t push_cmd;
    cmd_t head_cmd;
    logic run_end;
    err_t err;

    assign s_tready = !full;
    assign accept   = s_tvalid && !full;
    assign m_tuser  = {err, run_end};

    hfr_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .opcode         (s_tuser[0]),
        .type_code      (s_tdata[5:0]),
        .payload_length (s_tdata[37:6]),
        .payload_byte   (s_tdata[45:38]),
        .cmd            (push_cmd)
    );

    hfr_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (push_cmd),
        .full      (full),
        .pop       (pop),
        .pop_data  (head_cmd),
        .empty     (empty)
    );

    hfr_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (head_cmd),
        .empty         (empty),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_byte      (m_tdata),
        .out_frame_end (m_tlast),
        .out_run_end   (run_end),
        .out_err       (err)
    );

endmodule

>>> rtl/hfr_front.sv
// ----------------------------------------------------------------------------
// HTTP/3 frame framer front end
// Classifies input transfers, tracks the open frame and builds queue commands.
// ----------------------------------------------------------------------------
module hfr_front
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic         opcode,
    input  logic [5:0]   type_code,
    input  logic [31:0]  payload_length,
    input  logic [7:0]   payload_byte,
    output hfr_pkg::cmd_t cmd
);
    import hfr_pkg::*;

    logic [31:0] rem_reg;
    logic [31:0] rem_next;
    logic        in_frame_reg;
    logic        in_frame_next;

    always_comb
    begin
        rem_next      = rem_reg;
        in_frame_next = in_frame_reg;
        cmd.is_hdr    = 1'b0;
        cmd.vlen      = VLEN_1;
        cmd.ftype     = type_code;
        cmd.len       = payload_length;
        cmd.data      = payload_byte;
        cmd.frame_end = 1'b0;
        cmd.err       = ERR_OK;
        if (opcode == OP_START)
        begin
            cmd.is_hdr    = 1'b1;
            cmd.err       = in_frame_reg ? ERR_CUT : ERR_OK;
            cmd.frame_end = (payload_length == 32'd0);
            priority if (payload_length <= VARINT1_MAX)
                cmd.vlen = VLEN_1;
            else if (payload_length <= VARINT2_MAX)
                cmd.vlen = VLEN_2;
            else if (payload_length <= VARINT4_MAX)
                cmd.vlen = VLEN_4;
            else
                cmd.vlen = VLEN_8;
            rem_next      = payload_length;
            in_frame_next = (payload_length != 32'd0);
        end
        else if (!in_frame_reg)
        begin
            cmd.data = 8'h00;
            cmd.err  = ERR_DROP;
        end
        else
        begin
            rem_next      = rem_reg - 32'd1;
            cmd.frame_end = (rem_reg == 32'd1);
            in_frame_next = (rem_reg != 32'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg      <= '0;
            in_frame_reg <= 1'b0;
        end
        else if (accept)
        begin
            rem_reg      <= rem_next;
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

>>> rtl/hfr_fifo.sv
// ----------------------------------------------------------------------------
// HTTP/3 frame framer command queue
// Short first-in first-out queue between the front end and the byte emitter.
// ----------------------------------------------------------------------------
module hfr_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hfr_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output hfr_pkg::cmd_t pop_data,
    output logic          empty
);
    import hfr_pkg::*;

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("pop from empty queue");

endmodule

>>> rtl/hfr_back.sv
// ----------------------------------------------------------------------------
// HTTP/3 frame framer byte emitter
// Walks each queued command byte by byte into the registered output stage.
// ----------------------------------------------------------------------------
module hfr_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  hfr_pkg::cmd_t cmd,
    input  logic          empty,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          out_frame_end,
    output logic          out_run_end,
    output hfr_pkg::err_t out_err
);
    import hfr_pkg::*;

    logic [3:0] idx_reg;
    logic [3:0] last_idx;
    logic       at_last;
    logic       load;
    logic [7:0] byte_val;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_fe_reg;
    logic       out_run_reg;
    err_t       out_err_reg;

    assign last_idx = cmd.is_hdr ? hdr_last(cmd.vlen) : 4'd0;
    assign at_last  = (idx_reg == last_idx);
    assign load     = !empty && (!out_valid_reg || out_ready);
    assign pop      = load && at_last;
    assign byte_val = cmd.is_hdr ? hdr_byte(cmd.ftype, cmd.len, cmd.vlen, idx_reg) : cmd.data;

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign out_frame_end = out_fe_reg;
    assign out_run_end   = out_run_reg;
    assign out_err       = out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (load)
                idx_reg <= at_last ? 4'd0 : idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= byte_val;
            out_fe_reg   <= at_last && cmd.frame_end;
            out_run_reg  <= at_last;
            out_err_reg  <= cmd.err;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) (idx_reg != 4'd0) |-> !empty)
        else $error("command walk without queued command");
    assert property (@(posedge clk) disable iff (!rst_n) !empty |-> idx_reg <= last_idx)
        else $error("byte index past end of command");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (out_valid_reg && out_fe_reg) |-> out_run_reg)
        else $error("frame end without run end");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (out_valid_reg && out_err_reg == ERR_DROP) |-> (out_run_reg && !out_fe_reg))
        else $error("dropped byte marked as frame end");

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// HTTP/3 frame header framer testbench
// Sends start and payload transfers from a queue and predicts every output
// byte: the type byte, the varint length and each passed-through payload
// byte. The check covers byte value, frame end, run end and the error code.
// Both sides stall at random. A directed opening covers the varint length
// boundaries, zero-length frames, dropped payload bytes and cut frames. The
// random part that follows is mostly whole frames.
// ----------------------------------------------------------------------------
module tb;

    import hfr_pkg::*;

    localparam int unsigned CMD_COUNT   = 370;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_WAIT  = 20;

    typedef struct {
        op_e_t       op;
        logic [5:0]  ftype;
        logic [31:0] len;
        logic [7:0]  pbyte;
        int unsigned gap;
        bit          hold;
    } frame_cmd_t;

    typedef struct {
        logic [7:0] data;
        logic       frame_end;
        logic       run_end;
        err_t       err;
    } stream_byte_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;

    frame_cmd_t   cmd_q[$];
    stream_byte_t stream_bytes_q[$];

    logic [31:0] frm_left = '0;
    logic        frm_open = 1'b0;

    int unsigned fails     = 0;
    int unsigned cycle_cnt = 0;
    int unsigned took_cnt  = 0;
    int unsigned got_cnt   = 0;

    bit          tx_idle   = 1'b1;
    bit          tx_busy   = 1'b0;
    bit          gap_armed = 1'b0;
    int unsigned tx_gap    = 0;
    int unsigned sent_cnt  = 0;
    frame_cmd_t  tx_cur;

    bit          rx_idle   = 1'b1;
    int unsigned rx_wait   = 0;
    int unsigned seen_cnt  = 0;

    stream_byte_t got_exp;

    http3_frame_header_framer_top u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    task automatic frame_predict(input op_e_t op, input logic [5:0] ftype,
                                 input logic [31:0] len, input logic [7:0] pbyte);
        logic [7:0] hdr [0:8];
        int         n;
        err_t       e;
        if (op == OP_START)
        begin
            e      = frm_open ? ERR_CUT : ERR_OK;
            hdr[0] = {2'b00, ftype};
            if (len <= VARINT1_MAX)
            begin
                hdr[1] = len[7:0];
                n = 2;
            end
            else if (len <= VARINT2_MAX)
            begin
                hdr[1] = PREFIX2 | {2'b00, len[13:8]};
                hdr[2] = len[7:0];
                n = 3;
            end
            else if (len <= VARINT4_MAX)
            begin
                hdr[1] = PREFIX4 | {2'b00, len[29:24]};
                hdr[2] = len[23:16];
                hdr[3] = len[15:8];
                hdr[4] = len[7:0];
                n = 5;
            end
            else
            begin
                hdr[1] = PREFIX8;
                hdr[2] = 8'h00;
                hdr[3] = 8'h00;
                hdr[4] = 8'h00;
                hdr[5] = len[31:24];
                hdr[6] = len[23:16];
                hdr[7] = len[15:8];
                hdr[8] = len[7:0];
                n = 9;
            end
            for (int i = 0; i < n; i++)
            begin
                stream_bytes_q.push_back('{hdr[i], (i == n - 1) && (len == 0),
                                           i == n - 1, e});
            end
            frm_left = len;
            frm_open = (len != 0);
        end
        else if (!frm_open)
        begin
            stream_bytes_q.push_back('{8'h00, 1'b0, 1'b1, ERR_DROP});
        end
        else
        begin
            frm_left = frm_left - 1;
            if (frm_left == 0)
            begin
                frm_open = 1'b0;
            end
            stream_bytes_q.push_back('{pbyte, frm_left == 0, 1'b1, ERR_OK});
        end
    endtask

    task automatic queue_cmd(input op_e_t op, input logic [5:0] ftype,
                             input logic [31:0] len, input logic [7:0] pbyte);
        frame_cmd_t c;
        if (cmd_q.size() % 40 == 0)
        begin
            tx_idle = ($urandom_range(0, 2) != 0);
        end
        c.op    = op;
        c.ftype = ftype;
        c.len   = len;
        c.pbyte = pbyte;
        c.gap   = tx_idle ? $urandom_range(0, 8) : 0;
        c.hold  = (cmd_q.size() % 60 == 30);
        cmd_q.push_back(c);
    endtask

    task automatic queue_start(input logic [5:0] ftype, input logic [31:0] len);
        queue_cmd(OP_START, ftype, len, 8'($urandom));
    endtask

    task automatic queue_payload(input logic [7:0] pbyte);
        queue_cmd(OP_PAYLOAD, 6'($urandom), $urandom, pbyte);
    endtask

    // sender
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (tx_busy && sent_cnt != took_cnt)
            begin
                sent_cnt++;
                tx_busy = 1'b0;
            end
            if (!tx_busy && cmd_q.size() != 0)
            begin
                if (!gap_armed)
                begin
                    tx_gap    = cmd_q[0].gap;
                    gap_armed = 1'b1;
                end
                if (tx_gap != 0)
                begin
                    tx_gap--;
                end
                else if (!cmd_q[0].hold || stream_bytes_q.size() == 0)
                begin
                    tx_cur    = cmd_q.pop_front();
                    tx_busy   = 1'b1;
                    gap_armed = 1'b0;
                    s_tdata  <= {2'b00, tx_cur.pbyte, tx_cur.len, tx_cur.ftype};
                    s_tuser  <= tx_cur.op;
                end
            end
            s_tvalid <= tx_busy;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (got_cnt != seen_cnt)
            begin
                seen_cnt = got_cnt;
                if (seen_cnt % 40 == 0)
                begin
                    rx_idle = ($urandom_range(0, 2) != 0);
                end
                rx_wait = rx_idle ? $urandom_range(0, 8) : 0;
            end
            if (rx_wait != 0)
            begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                frame_predict(op_e_t'(s_tuser[0]), s_tdata[5:0], s_tdata[37:6],
                              s_tdata[45:38]);
                took_cnt <= took_cnt + 1;
            end
            if (m_tvalid && m_tready)
            begin
                got_cnt <= got_cnt + 1;
                if (stream_bytes_q.size() == 0)
                begin
                    $error("unexpected transfer: out_byte %0h", m_tdata);
                    fails++;
                end
                else
                begin
                    got_exp = stream_bytes_q.pop_front();
                    if (m_tdata !== got_exp.data)
                    begin
                        $error("out_byte: expected %0h, got %0h", got_exp.data, m_tdata);
                        fails++;
                    end
                    if (m_tlast !== got_exp.frame_end)
                    begin
                        $error("frame_end: expected %0d, got %0d", got_exp.frame_end,
                               m_tlast);
                        fails++;
                    end
                    if (m_tuser[0] !== got_exp.run_end)
                    begin
                        $error("run_end: expected %0d, got %0d", got_exp.run_end,
                               m_tuser[0]);
                        fails++;
                    end
                    if (m_tuser[2:1] !== got_exp.err)
                    begin
                        $error("error: expected %0d, got %0d", got_exp.err, m_tuser[2:1]);
                        fails++;
                    end
                end
            end
        end
    end

    initial
    begin
        int unsigned r;
        int unsigned cls;
        int unsigned nb;
        logic [31:0] len;

        // drop outside a frame, zero-length frame, single-byte frame
        queue_payload(8'hA5);
        queue_start(6'd0, 32'd0);
        queue_payload(8'h00);
        queue_start(6'd63, 32'd1);
        queue_payload(8'hFF);
        // varint boundaries, most of these starts cutting the open frame
        queue_start(6'd7, VARINT1_MAX);
        queue_payload(8'h00);
        queue_start(6'd1, VARINT1_MAX + 1);
        queue_start(6'd0, VARINT2_MAX);
        queue_start(6'd42, VARINT2_MAX + 1);
        queue_start(6'd21, VARINT4_MAX);
        queue_start(6'd63, VARINT4_MAX + 1);
        queue_start(6'd63, 32'hFFFF_FFFF);
        queue_start(6'd0, 32'hAAAA_5555);
        queue_start(6'd2, 32'd2);
        queue_payload(8'h5A);
        queue_payload(8'hFF);
        queue_payload(8'h01);
        queue_start(6'd7, 32'd0);
        queue_start(6'd1, 32'd3);
        queue_payload(8'h80);
        queue_start(6'd1, 32'd0);

        while (cmd_q.size() < CMD_COUNT)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                cls = $urandom_range(0, 99);
                if (cls < 8)
                begin
                    len = 32'd0;
                end
                else if (cls < 80)
                begin
                    len = $urandom_range(1, 12);
                end
                else if (cls < 88)
                begin
                    len = $urandom_range(13, 63);
                end
                else if (cls < 93)
                begin
                    len = $urandom_range(64, 16383);
                end
                else if (cls < 97)
                begin
                    len = $urandom_range(16384, VARINT4_MAX);
                end
                else
                begin
                    len = $urandom;
                    if (len <= VARINT4_MAX)
                    begin
                        len = len | 32'h4000_0000;
                    end
                end
                queue_start(6'($urandom), len);
                if (len > 63)
                begin
                    nb = $urandom_range(0, 4);
                end
                else
                begin
                    nb = len;
                    cls = $urandom_range(0, 99);
                    if (cls < 10 && nb != 0)
                    begin
                        nb = $urandom_range(0, nb - 1);
                    end
                    else if (cls < 20)
                    begin
                        nb = nb + 1;
                    end
                end
                for (int i = 0; i < nb; i++)
                begin
                    queue_payload(8'($urandom));
                end
            end
            else if (r < 90)
            begin
                queue_payload(8'($urandom));
            end
            else
            begin
                queue_start(6'($urandom), $urandom);
                nb = $urandom_range(0, 3);
                for (int i = 0; i < nb; i++)
                begin
                    queue_payload(8'($urandom));
                end
            end
        end

        while (cmd_q.size() != 0 || s_tvalid)
        begin
            @(posedge clk);
        end
        while (stream_bytes_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fails == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
